// ===== hdl/nsf_pkg.sv =====
// Package for the NMEA sentence framer: phase and kind codes, character constants,
// the result word type and the hex digit decoder.
// No dependencies.
package nsf_pkg;

	// Parser phase within one sentence.
	typedef enum logic [1:0] {
		PH_WAIT   = 2'd0,
		PH_BODY   = 2'd1,
		PH_DIGITS = 2'd2,
		PH_TAIL   = 2'd3
	} phase_t;

	// Sentence type codes as reported on message_kind.
	typedef enum logic [1:0] {
		KIND_RMC = 2'd0,
		KIND_GGA = 2'd1,
		KIND_GSA = 2'd2
	} kind_t;

	// Longest body that is counted and folded into the checksum.
	localparam logic [6:0] LINE_LENGTH_MAX = 7'd80;

	// Number of leading body bytes kept as the header.
	localparam int HEADER_LEN = 6;
	localparam logic [6:0] HEADER_LEN_W = 7'd6;

	// Characters that the parser recognizes.
	localparam logic [7:0] CHAR_DOLLAR = 8'h24;
	localparam logic [7:0] CHAR_STAR   = 8'h2A;
	localparam logic [7:0] CHAR_CR     = 8'h0D;
	localparam logic [7:0] CHAR_LF     = 8'h0A;
	localparam logic [7:0] CHAR_COMMA  = 8'h2C;
	localparam logic [7:0] CHAR_R      = 8'h52;
	localparam logic [7:0] CHAR_M      = 8'h4D;
	localparam logic [7:0] CHAR_C      = 8'h43;
	localparam logic [7:0] CHAR_G      = 8'h47;
	localparam logic [7:0] CHAR_S      = 8'h53;
	localparam logic [7:0] CHAR_A      = 8'h41;

	// One result word.
	typedef struct packed {
		logic [1:0] message_kind;
		logic [7:0] talker_first;
		logic [7:0] talker_second;
		logic [6:0] body_length;
		logic [7:0] checksum_value;
	} result_t;

	// Decoded hex digit.
	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	// Decodes one ASCII hex digit, upper or lower case.
	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t h;
		h.ok  = 1'b0;
		h.val = c[3:0];
		if (c >= 8'h30 && c <= 8'h39) begin
			h.ok  = 1'b1;
			h.val = c[3:0];
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			h.ok  = 1'b1;
			h.val = c[3:0] + 4'd9;
		end
		return h;
	endfunction

endpackage

// ===== hdl/nsf_in_reg.sv =====
// Input register of the NMEA sentence framer: holds one received word until the
// parser takes it. Depends on nothing but the clock and reset.
module nsf_in_reg (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       consume,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	logic accept;

	assign accept = in_valid && !in_stall;

	// Occupancy: a new word refills the stage in the same cycle the old one leaves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

// ===== hdl/nsf_parser.sv =====
// Sentence parser of the NMEA framer: phase machine, body count, running XOR,
// header and checksum digit stores, and the result decision. Uses nsf_pkg.
module nsf_parser
	import nsf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] byte_in,
	output logic       produce,
	output result_t    result
);

	phase_t     phase_q, phase_d;
	logic [6:0] body_count_q;
	logic       overflowed_q;
	logic [7:0] running_xor_q;
	logic       digit_cnt_q;
	logic [7:0] digit_hi_q;
	logic [7:0] digit_lo_q;
	logic [7:0] header_q [HEADER_LEN];

	logic is_dollar, is_star, line_end;
	logic clear_sentence, body_take, overflow_set, digit_take, tail_end;
	logic header_write;
	hex_t hex_hi, hex_lo;
	logic sum_ok, header_ok, kind_ok;
	kind_t kind;

	assign is_dollar = (byte_in == CHAR_DOLLAR);
	assign is_star   = (byte_in == CHAR_STAR);
	assign line_end  = (byte_in == CHAR_CR) || (byte_in == CHAR_LF);

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_WAIT: begin
				if (is_dollar) phase_d = PH_BODY;
			end
			PH_BODY: begin
				if (is_star) phase_d = PH_DIGITS;
				else if (line_end) phase_d = PH_WAIT;
			end
			PH_DIGITS: begin
				if (line_end) phase_d = PH_WAIT;
				else if (digit_cnt_q) phase_d = PH_TAIL;
			end
			PH_TAIL: begin
				if (line_end) phase_d = PH_WAIT;
			end
		endcase
	end

	// Datapath controls for the current word.
	always_comb begin
		clear_sentence = 1'b0;
		body_take      = 1'b0;
		overflow_set   = 1'b0;
		digit_take     = 1'b0;
		tail_end       = 1'b0;
		unique case (phase_q)
			PH_WAIT: begin
				clear_sentence = is_dollar;
			end
			PH_BODY: begin
				if (!is_star && line_end) begin
					clear_sentence = 1'b1;
				end else if (!is_star) begin
					body_take    = (body_count_q < LINE_LENGTH_MAX);
					overflow_set = !(body_count_q < LINE_LENGTH_MAX);
				end
			end
			PH_DIGITS: begin
				clear_sentence = line_end;
				digit_take     = !line_end;
			end
			PH_TAIL: begin
				clear_sentence = line_end;
				tail_end       = line_end;
			end
		endcase
	end

	assign header_write = body_take && (body_count_q < HEADER_LEN_W);

	// Checksum and header checks at the end of a line.
	assign hex_hi    = hex_decode(digit_hi_q);
	assign hex_lo    = hex_decode(digit_lo_q);
	assign sum_ok    = hex_hi.ok && hex_lo.ok && ({hex_hi.val, hex_lo.val} == running_xor_q);
	assign header_ok = (body_count_q >= HEADER_LEN_W) && (header_q[5] == CHAR_COMMA);

	always_comb begin
		kind    = KIND_RMC;
		kind_ok = 1'b0;
		if (header_q[2] == CHAR_R && header_q[3] == CHAR_M && header_q[4] == CHAR_C) begin
			kind    = KIND_RMC;
			kind_ok = 1'b1;
		end else if (header_q[2] == CHAR_G && header_q[3] == CHAR_G
				&& header_q[4] == CHAR_A) begin
			kind    = KIND_GGA;
			kind_ok = 1'b1;
		end else if (header_q[2] == CHAR_G && header_q[3] == CHAR_S
				&& header_q[4] == CHAR_A) begin
			kind    = KIND_GSA;
			kind_ok = 1'b1;
		end
	end

	assign produce = step && tail_end && !overflowed_q && sum_ok && header_ok && kind_ok;

	assign result.message_kind   = kind;
	assign result.talker_first   = header_q[0];
	assign result.talker_second  = header_q[1];
	assign result.body_length    = body_count_q;
	assign result.checksum_value = running_xor_q;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_WAIT;
			body_count_q  <= 7'd0;
			overflowed_q  <= 1'b0;
			running_xor_q <= 8'd0;
			digit_cnt_q   <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			if (clear_sentence) begin
				body_count_q  <= 7'd0;
				overflowed_q  <= 1'b0;
				running_xor_q <= 8'd0;
				digit_cnt_q   <= 1'b0;
			end else begin
				if (body_take) begin
					body_count_q  <= body_count_q + 7'd1;
					running_xor_q <= running_xor_q ^ byte_in;
				end
				if (overflow_set) overflowed_q <= 1'b1;
				if (digit_take) digit_cnt_q <= 1'b1;
			end
		end
	end

	// Header and digit stores; valid only once written.
	always_ff @(posedge clk) begin
		if (step && header_write) begin
			header_q[body_count_q[2:0]] <= byte_in;
		end
		if (step && digit_take && !digit_cnt_q) begin
			digit_hi_q <= byte_in;
		end
		if (step && digit_take && digit_cnt_q) begin
			digit_lo_q <= byte_in;
		end
	end

	// The body count never passes the length limit.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		body_count_q <= LINE_LENGTH_MAX)
		else $error("body count beyond limit");

	// Overflow is flagged only with a full body.
	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		overflowed_q |-> body_count_q == LINE_LENGTH_MAX)
		else $error("overflow flagged before body was full");

	// A result leaves only from the tail phase of a sentence without overflow.
	a_result_tail: assert property (@(posedge clk) disable iff (!arst_n)
		produce |-> (phase_q == PH_TAIL) && !overflowed_q)
		else $error("result outside tail phase");

	// A line end always returns the parser to waiting.
	a_line_end_waits: assert property (@(posedge clk) disable iff (!arst_n)
		step && line_end |=> phase_q == PH_WAIT)
		else $error("line end did not return to waiting");

	// While waiting, the sentence state is clear.
	a_wait_clear: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_WAIT |-> body_count_q == 7'd0 && running_xor_q == 8'd0
			&& !overflowed_q)
		else $error("sentence state not clear while waiting");

endmodule

// ===== hdl/nsf_out_reg.sv =====
// Output register of the NMEA sentence framer: holds one result word until the
// receiver takes it. Uses nsf_pkg for the result type.
module nsf_out_reg
	import nsf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  result_t    result_in,
	input  logic       out_stall,
	output logic       out_free,
	output logic       out_valid,
	output logic [1:0] message_kind,
	output logic [7:0] talker_first,
	output logic [7:0] talker_second,
	output logic [6:0] body_length,
	output logic [7:0] checksum_value
);

	result_t res_q;

	// The slot can take a word when empty or when its word leaves this cycle.
	assign out_free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= result_in;
		end
	end

	assign message_kind   = res_q.message_kind;
	assign talker_first   = res_q.talker_first;
	assign talker_second  = res_q.talker_second;
	assign body_length    = res_q.body_length;
	assign checksum_value = res_q.checksum_value;

endmodule

// ===== hdl/nmea_sentence_framer_top.sv =====
// NMEA sentence framer top level: input register, sentence parser, output register.
// Depends on nsf_pkg, nsf_in_reg, nsf_parser and nsf_out_reg.
//
// Usage:
//   The input channel (in_valid, in_stall, rx_byte) takes one received character
//   per word. A '$' opens a sentence, '*' ends the body, two hex digits follow,
//   and CR or LF closes the line. The output channel (out_valid, out_stall and the
//   result fields) gives one word for each line whose checksum matches, whose body
//   fits LINE_LENGTH_MAX and whose header names an RMC, GGA or GSA sentence and a comma;
//   other lines give nothing. Throughput is one character per cycle while the output
//   slot is free: the parser updates its state on the character in the input register.
//   The closing CR or LF is registered in the input register, and the parser then
//   loads the result word into the output register, which raises out_valid.
//   When the receiver stalls with a result held, the parser holds its next
//   character and in_stall rises once the input register is occupied; nothing is
//   dropped. Reset clears all valid flags and returns the parser to waiting for '$'.
module nmea_sentence_framer_top
	import nsf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] message_kind,
	output logic [7:0] talker_first,
	output logic [7:0] talker_second,
	output logic [6:0] body_length,
	output logic [7:0] checksum_value
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_free;
	logic       step;
	logic       produce;
	result_t    result;

	// The parser steps whenever a character is held and the output slot is free.
	assign step     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	nsf_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.consume  (step),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	nsf_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.byte_in (byte_s1),
		.produce (produce),
		.result  (result)
	);

	nsf_out_reg u_out_reg (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (produce),
		.result_in      (result),
		.out_stall      (out_stall),
		.out_free       (out_free),
		.out_valid      (out_valid),
		.message_kind   (message_kind),
		.talker_first   (talker_first),
		.talker_second  (talker_second),
		.body_length    (body_length),
		.checksum_value (checksum_value)
	);

endmodule

// ===== tb/tb_nmea_sentence_framer_top.sv =====
// Testbench for nmea_sentence_framer_top: sends byte streams of framed and damaged
// sentences and checks every result word against a cycle-free predictor of the framer.
// Depends on nsf_pkg and nmea_sentence_framer_top.
module tb_nmea_sentence_framer_top;
	import nsf_pkg::*;

	// Ways in which a generated sentence can be damaged.
	typedef enum int {
		SOUND,
		BAD_SUM,
		BAD_HEX,
		CUT_BODY,
		CUT_DIGITS
	} flaw_t;

	localparam logic [23:0] ID_RMC = {CHAR_R, CHAR_M, CHAR_C};
	localparam logic [23:0] ID_GGA = {CHAR_G, CHAR_G, CHAR_A};
	localparam logic [23:0] ID_GSA = {CHAR_G, CHAR_S, CHAR_A};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [1:0] message_kind;
	logic [7:0] talker_first;
	logic [7:0] talker_second;
	logic [6:0] body_length;
	logic [7:0] checksum_value;

	// Predictor state of the sentence framer.
	phase_t     fr_phase = PH_WAIT;
	logic [6:0] fr_count = '0;
	logic       fr_over = 1'b0;
	logic [7:0] fr_xor = '0;
	logic [7:0] fr_digit [2];
	logic [1:0] fr_dcnt = '0;
	logic [7:0] fr_hdr [6];

	// Sentences that passed every check and are still owed by the block.
	result_t    valid_sentences [$];
	result_t    want;

	logic [7:0] line_buf [$];
	int         tx_idle_pct = 0;
	int         rx_idle_pct = 0;
	int         digit_style = 2;
	logic       hold_active = 1'b0;
	event       start_hold;
	int         failures = 0;
	int         bytes_taken = 0;
	int         sentences_seen = 0;

	nmea_sentence_framer_top uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.message_kind   (message_kind),
		.talker_first   (talker_first),
		.talker_second  (talker_second),
		.body_length    (body_length),
		.checksum_value (checksum_value)
	);

	always #5 clk = ~clk;

	// Value of an ASCII hex digit, or -1 when the character is not one.
	function automatic int nibble_of(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c - "0");
		if (c >= "A" && c <= "F") return int'(c - "A") + 10;
		if (c >= "a" && c <= "f") return int'(c - "a") + 10;
		return -1;
	endfunction

	function automatic bit is_line_end(input logic [7:0] c);
		return c == CHAR_CR || c == CHAR_LF;
	endfunction

	// Decodes the kept header; returns 0 when it names no known sentence.
	function automatic bit header_kind(output kind_t k);
		logic [23:0] id;
		k = KIND_RMC;
		if (fr_count < HEADER_LEN_W || fr_hdr[5] != CHAR_COMMA) return 1'b0;
		id = {fr_hdr[2], fr_hdr[3], fr_hdr[4]};
		if (id == ID_RMC) begin
			k = KIND_RMC;
			return 1'b1;
		end
		if (id == ID_GGA) begin
			k = KIND_GGA;
			return 1'b1;
		end
		if (id == ID_GSA) begin
			k = KIND_GSA;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic drop_sentence();
		fr_phase = PH_WAIT;
		fr_count = '0;
		fr_over = 1'b0;
		fr_xor = '0;
		fr_dcnt = '0;
	endtask

	// Advances the framer by one accepted byte and queues any sentence it completes.
	task automatic parse_char(input logic [7:0] b);
		kind_t   k;
		int      hi;
		int      lo;
		result_t r;
		case (fr_phase)
			PH_WAIT: begin
				if (b == CHAR_DOLLAR) begin
					drop_sentence();
					fr_phase = PH_BODY;
				end
			end
			PH_BODY: begin
				if (b == CHAR_STAR) begin
					fr_phase = PH_DIGITS;
				end else if (is_line_end(b)) begin
					drop_sentence();
				end else if (fr_count < LINE_LENGTH_MAX) begin
					if (fr_count < HEADER_LEN_W) fr_hdr[fr_count] = b;
					fr_xor = fr_xor ^ b;
					fr_count = fr_count + 7'd1;
				end else begin
					fr_over = 1'b1;
				end
			end
			PH_DIGITS: begin
				if (is_line_end(b)) begin
					drop_sentence();
				end else begin
					fr_digit[fr_dcnt[0]] = b;
					fr_dcnt = fr_dcnt + 2'd1;
					if (fr_dcnt >= 2'd2) fr_phase = PH_TAIL;
				end
			end
			default: begin
				if (is_line_end(b)) begin
					hi = nibble_of(fr_digit[0]);
					lo = nibble_of(fr_digit[1]);
					if (!fr_over && hi >= 0 && lo >= 0 && fr_xor == 8'(hi * 16 + lo)
							&& header_kind(k)) begin
						r.message_kind = k;
						r.talker_first = fr_hdr[0];
						r.talker_second = fr_hdr[1];
						r.body_length = fr_count;
						r.checksum_value = fr_xor;
						valid_sentences.push_back(r);
					end
					drop_sentence();
				end
			end
		endcase
	endtask

	// Input side: every accepted byte goes through the predictor.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			parse_char(rx_byte);
			bytes_taken++;
		end
	end

	// Output side: each accepted word must match the oldest owed sentence.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (valid_sentences.size() == 0) begin
				$error("result word with no sentence owed: kind %0d length %0d",
					message_kind, body_length);
				failures++;
			end else begin
				want = valid_sentences.pop_front();
				sentences_seen++;
				if (message_kind !== want.message_kind) begin
					$error("message_kind: expected %0d, got %0d",
						want.message_kind, message_kind);
					failures++;
				end
				if (talker_first !== want.talker_first) begin
					$error("talker_first: expected %0h, got %0h",
						want.talker_first, talker_first);
					failures++;
				end
				if (talker_second !== want.talker_second) begin
					$error("talker_second: expected %0h, got %0h",
						want.talker_second, talker_second);
					failures++;
				end
				if (body_length !== want.body_length) begin
					$error("body_length: expected %0d, got %0d",
						want.body_length, body_length);
					failures++;
				end
				if (checksum_value !== want.checksum_value) begin
					$error("checksum_value: expected %0h, got %0h",
						want.checksum_value, checksum_value);
					failures++;
				end
			end
		end
	end

	// Receiver: random stalls, forced high for the whole of a long hold-off.
	always @(posedge clk) begin
		out_stall <= hold_active || ($urandom_range(0, 99) < rx_idle_pct);
	end

	// Long receiver hold-off, counted here in clock cycles.
	always begin
		@(start_hold);
		hold_active <= 1'b1;
		repeat (300) @(posedge clk);
		hold_active <= 1'b0;
	end

	// Offers one byte and returns at the edge where it is accepted.
	task automatic send_word(input logic [7:0] b);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic flush_line();
		for (int i = 0; i < line_buf.size(); i++) send_word(line_buf[i]);
		line_buf.delete();
	endtask

	// Stops sending until every owed sentence has come out, then lets the pipe settle.
	// The first edge lets the predictor take the last accepted byte.
	task automatic wait_idle();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		@(posedge clk);
		while (valid_sentences.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		bit lower;
		lower = (digit_style == 1) || (digit_style == 2 && $urandom_range(0, 1) == 1);
		if (n < 4'd10) return 8'("0" + n);
		return lower ? 8'("a" + n - 10) : 8'("A" + n - 10);
	endfunction

	// Any byte that keeps a sentence body open, mostly printable.
	function automatic logic [7:0] body_byte();
		logic [7:0] c;
		do begin
			if ($urandom_range(0, 4) != 0) c = 8'($urandom_range(32, 126));
			else c = 8'($urandom_range(0, 255));
		end while (c == CHAR_STAR || is_line_end(c));
		return c;
	endfunction

	function automatic logic [7:0] non_hex_byte();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255));
		while (nibble_of(c) >= 0 || is_line_end(c));
		return c;
	endfunction

	task automatic push_line_end();
		case ($urandom_range(0, 2))
			0: line_buf.push_back(CHAR_CR);
			1: line_buf.push_back(CHAR_LF);
			default: begin
				line_buf.push_back(CHAR_CR);
				line_buf.push_back(CHAR_LF);
			end
		endcase
	endtask

	// Builds and sends one line: '$', the first hdr_len bytes of hdr, extra payload
	// bytes, then '*', checksum digits, trailing bytes (tail < 0 picks at random)
	// and a line end, damaged as the flaw says.
	task automatic send_sentence(input logic [47:0] hdr, input int hdr_len, input int extra,
			input int tail, input flaw_t flaw);
		logic [7:0] sum;
		logic [7:0] c;
		logic [7:0] hi;
		logic [7:0] lo;
		int         n;
		sum = '0;
		line_buf.push_back(CHAR_DOLLAR);
		for (int i = 0; i < hdr_len; i++) begin
			c = hdr[47 - 8 * i -: 8];
			line_buf.push_back(c);
			sum ^= c;
		end
		for (int i = 0; i < extra; i++) begin
			c = body_byte();
			line_buf.push_back(c);
			sum ^= c;
		end
		if (flaw == CUT_BODY) begin
			push_line_end();
		end else begin
			line_buf.push_back(CHAR_STAR);
			if (flaw == BAD_SUM) sum ^= 8'(1 << $urandom_range(0, 7));
			hi = hex_char(sum[7:4]);
			lo = hex_char(sum[3:0]);
			if (flaw == CUT_DIGITS) begin
				if ($urandom_range(0, 1) == 1) line_buf.push_back(hi);
				push_line_end();
			end else begin
				if (flaw == BAD_HEX) begin
					if ($urandom_range(0, 1) == 1) hi = non_hex_byte();
					else lo = non_hex_byte();
				end
				line_buf.push_back(hi);
				line_buf.push_back(lo);
				n = tail;
				if (n < 0) n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
				for (int i = 0; i < n; i++) begin
					do c = 8'($urandom_range(0, 255));
					while (is_line_end(c));
					line_buf.push_back(c);
				end
				push_line_end();
			end
		end
		flush_line();
	endtask

	// Bytes between sentences; any value but '$'.
	task automatic send_noise(input int count);
		logic [7:0] c;
		for (int i = 0; i < count; i++) begin
			do c = 8'($urandom_range(0, 255));
			while (c == CHAR_DOLLAR);
			send_word(c);
		end
	endtask

	// One sentence drawn mostly well formed, with random content and occasional damage.
	task automatic send_random_sentence();
		logic [15:0] talker;
		logic [23:0] id;
		logic [7:0]  sep;
		logic [55:0] pool;
		int          hdr_len;
		int          extra;
		int          r;
		flaw_t       flaw;
		pool = "RMCGSAV";
		case ($urandom_range(0, 3))
			0, 1: talker = "GP";
			2: talker = "GN";
			default: talker = {body_byte(), body_byte()};
		endcase
		r = $urandom_range(0, 99);
		if (r < 28) id = ID_RMC;
		else if (r < 56) id = ID_GGA;
		else if (r < 85) id = ID_GSA;
		else id = {pool[8 * $urandom_range(0, 6) +: 8], pool[8 * $urandom_range(0, 6) +: 8],
			pool[8 * $urandom_range(0, 6) +: 8]};
		sep = ($urandom_range(0, 9) != 0) ? CHAR_COMMA : body_byte();
		hdr_len = ($urandom_range(0, 99) < 92) ? 6 : $urandom_range(0, 5);
		r = $urandom_range(0, 99);
		if (r < 85) extra = $urandom_range(0, 12);
		else if (r < 95) extra = $urandom_range(13, 60);
		else extra = $urandom_range(70, 90);
		r = $urandom_range(0, 99);
		if (r < 75) flaw = SOUND;
		else flaw = flaw_t'($urandom_range(1, 4));
		send_sentence({talker, id, sep}, hdr_len, extra, -1, flaw);
	endtask

	// Bytes outside a sentence, including line ends and high-bit values.
	task automatic test_waiting_noise();
		send_word(8'h00);
		send_word(8'hFF);
		send_word(CHAR_STAR);
		send_word(CHAR_CR);
		send_word(CHAR_LF);
		send_word(CHAR_A);
		wait_idle();
	endtask

	// Each sentence type, both digit cases, '$' inside the body and trailing bytes.
	task automatic test_sentence_kinds();
		digit_style = 0;
		send_sentence("GPRMC,", 6, 4, 0, SOUND);
		digit_style = 1;
		send_sentence("GNGGA,", 6, 0, 0, SOUND);
		digit_style = 2;
		send_sentence("GLGSA,", 6, 3, 2, SOUND);
		send_sentence("$PRMC,", 6, 5, 0, SOUND);
		send_sentence({8'hFF, 8'h80, "GSA,"}, 6, 1, 3, SOUND);
		wait_idle();
	endtask

	// Lines that must give nothing, and the longest body that still counts.
	task automatic test_line_faults();
		send_sentence("GPGGA,", 6, 74, 0, SOUND);
		send_sentence("GPGGA,", 6, 75, 0, SOUND);
		send_sentence("GPRMC,", 6, 90, 0, SOUND);
		send_sentence("GPRMC,", 6, 3, 0, CUT_BODY);
		send_sentence("GPGSA,", 6, 3, 0, CUT_DIGITS);
		send_sentence("GPGSA,", 6, 2, 0, CUT_DIGITS);
		send_sentence("GPRMC,", 6, 2, 0, BAD_HEX);
		send_sentence("GPGGA,", 6, 2, 0, BAD_SUM);
		send_sentence("GPRMC,", 5, 0, 0, SOUND);
		send_sentence("GPRMC,", 0, 0, 0, SOUND);
		send_sentence("GPRMC;", 6, 2, 0, SOUND);
		send_sentence("GPGSV,", 6, 2, 0, SOUND);
		send_sentence("GPrmc,", 6, 2, 0, SOUND);
		wait_idle();
	endtask

	// Random sentences and noise under one setting of the idle rates.
	task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int count);
		int start;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		start = bytes_taken;
		while (bytes_taken - start < count) begin
			if ($urandom_range(0, 99) < 15) send_noise($urandom_range(1, 4));
			send_random_sentence();
		end
		wait_idle();
	endtask

	// Long receiver hold-off while the sender keeps offering good sentences.
	task automatic test_output_holdoff();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		->start_hold;
		for (int i = 0; i < 10; i++) send_sentence("GPGGA,", 6, $urandom_range(0, 6), 0, SOUND);
		wait_idle();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_waiting_noise();
		test_sentence_kinds();
		test_line_faults();
		test_random_traffic(13, 74, 130);
		test_random_traffic(74, 13, 130);
		test_random_traffic(0, 0, 130);
		test_output_holdoff();
		repeat (10) @(posedge clk);
		if (valid_sentences.size() != 0) begin
			$error("%0d expected sentences never came out", valid_sentences.size());
			failures += valid_sentences.size();
		end
		$display("Framed %0d bytes into %0d checked sentences, covering damaged lines,",
			bytes_taken, sentences_seen);
		$display("body overflow, all idle patterns and a long output hold-off.");
		if (failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#5000000;
		$display("Timeout: the framer stopped moving words");
		$display("Test completed with failures");
		$finish;
	end

endmodule
